>>> src/astc_pkg.sv
// Shared types and constants of the accelerometer self-test checker.
package astc_pkg;

   localparam int AXES      = 3;
   localparam int SAMPLE_W  = 13;
   localparam int CHANGE_W  = 14;
   localparam int STATUS_W  = 3;
   localparam int PHASE_W   = 2;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_W     = 40;
   localparam int RSP_W     = 128;

   localparam logic KIND_BEGIN  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_UNKNOWN   = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_TESTING   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_INIT_FAIL = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_PASSED    = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FAILED    = 3'd4;

   localparam logic [PHASE_W-1:0] PH_OFF    = 2'd0;
   localparam logic [PHASE_W-1:0] PH_NORMAL = 2'd1;
   localparam logic [PHASE_W-1:0] PH_STIM   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_X_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_MIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_MAX = 3'd5;

   localparam logic signed [CHANGE_W-1:0] CHANGE_MIN_RST = 14'sh2000;
   localparam logic signed [CHANGE_W-1:0] CHANGE_MAX_RST = 14'sh1FFF;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [CHANGE_W-1:0] change_type;

   typedef struct packed {
      logic clear;
      logic add;
      logic div_load;
      logic div_step;
      logic store_normal;
      logic store_stim;
   } lane_ctrl_type;

endpackage

>>> src/accel_self_test_checker_unit.sv
// Top level of the accelerometer self-test checker.
// Every request yields one response. A begin request, an ignored sample or a sample
// that does not close a phase is accepted, then the response register is loaded. The
// sample that closes a collection phase is accepted, then the sum magnitude is loaded,
// multiplied by the reciprocal of SAMPLES, the average stored (after it the window check
// at the end of the stimulus phase) and the response register loaded; a response not yet
// taken stalls the next one. A new request is taken while the previous response still waits.
module accel_self_test_checker_unit #(
   parameter int SAMPLES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // device_present, sample_x, sample_y, sample_z
   input  logic [astc_pkg::REQ_W-1:0]          req_tdata,
   // kind
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status, test_passed, stimulus_request, normal_avg_x/y/z, stim_avg_x/y/z,
   // change_x/y/z, zero fill
   output logic [astc_pkg::RSP_W-1:0]          rsp_tdata,
   input  logic                                csr_we,
   input  logic [astc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [astc_pkg::CHANGE_W-1:0]       csr_wdata
);

   localparam int CNT_W  = $clog2(SAMPLES + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_STORE = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]                      state_ff, state_in;
   logic [astc_pkg::PHASE_W-1:0]    phase_ff, phase_in;
   logic [astc_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic                            passed_ff, passed_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [astc_pkg::RSP_W-1:0]      rsp_data_ff, rsp_data_in;
   astc_pkg::change_type            lim_lo_ff [astc_pkg::AXES];
   astc_pkg::change_type            lim_hi_ff [astc_pkg::AXES];

   astc_pkg::lane_ctrl_type         lane_ctrl;
   astc_pkg::sample_type            lane_sample [astc_pkg::AXES];
   astc_pkg::sample_type            normal_avg  [astc_pkg::AXES];
   astc_pkg::sample_type            stim_avg    [astc_pkg::AXES];
   astc_pkg::change_type            change      [astc_pkg::AXES];
   astc_pkg::change_type            change_out  [astc_pkg::AXES];
   logic                            window_ok;
   logic                            req_fire;
   logic                            rsp_free;
   logic                            done;
   logic [CNT_W-1:0]                count_next;

   assign lane_sample[0] = req_tdata[13:1];
   assign lane_sample[1] = req_tdata[26:14];
   assign lane_sample[2] = req_tdata[39:27];

   for (genvar a = 0; a < astc_pkg::AXES; a++) begin : g_lane
      astc_lane #(
         .SAMPLES (SAMPLES)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl),
         .sample     (lane_sample[a]),
         .normal_avg (normal_avg[a]),
         .stim_avg   (stim_avg[a]),
         .change     (change[a])
      );
   end

   astc_window u_window (
      .change (change),
      .lim_lo (lim_lo_ff),
      .lim_hi (lim_hi_ff),
      .ok     (window_ok)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign done       = (status_ff == astc_pkg::STAT_PASSED) ||
                       (status_ff == astc_pkg::STAT_FAILED);
   assign count_next = count_ff + 1'b1;

   always_comb begin
      for (int a = 0; a < astc_pkg::AXES; a++) begin
         change_out[a] = done ? change[a] : '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      status_in    = status_ff;
      passed_in    = passed_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      lane_ctrl    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EMIT;
               if (req_tuser == astc_pkg::KIND_BEGIN) begin
                  lane_ctrl.clear = 1'b1;
                  passed_in       = 1'b0;
                  count_in        = '0;
                  if (req_tdata[0]) begin
                     status_in = astc_pkg::STAT_TESTING;
                     phase_in  = astc_pkg::PH_NORMAL;
                  end else begin
                     status_in = astc_pkg::STAT_INIT_FAIL;
                     phase_in  = astc_pkg::PH_OFF;
                  end
               end else if (phase_ff inside {astc_pkg::PH_NORMAL, astc_pkg::PH_STIM}) begin
                  lane_ctrl.add = 1'b1;
                  if (count_next == CNT_W'(SAMPLES)) begin
                     count_in = '0;
                     state_in = ST_LOAD;
                  end else begin
                     count_in = count_next;
                  end
               end
            end
         end
         ST_LOAD: begin
            lane_ctrl.div_load = 1'b1;
            state_in           = ST_DIV;
         end
         ST_DIV: begin
            lane_ctrl.div_step = 1'b1;
            state_in           = ST_STORE;
         end
         ST_STORE: begin
            if (phase_ff == astc_pkg::PH_NORMAL) begin
               lane_ctrl.store_normal = 1'b1;
               phase_in               = astc_pkg::PH_STIM;
               state_in               = ST_EMIT;
            end else begin
               lane_ctrl.store_stim = 1'b1;
               state_in             = ST_CHECK;
            end
         end
         ST_CHECK: begin
            passed_in = window_ok;
            status_in = window_ok ? astc_pkg::STAT_PASSED : astc_pkg::STAT_FAILED;
            phase_in  = astc_pkg::PH_OFF;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000,
                               change_out[2], change_out[1], change_out[0],
                               stim_avg[2], stim_avg[1], stim_avg[0],
                               normal_avg[2], normal_avg[1], normal_avg[0],
                               (phase_ff == astc_pkg::PH_STIM), passed_ff, status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= astc_pkg::PH_OFF;
         status_ff    <= astc_pkg::STAT_UNKNOWN;
         passed_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         status_ff    <= status_in;
         passed_ff    <= passed_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < astc_pkg::AXES; a++) begin
            lim_lo_ff[a] <= astc_pkg::CHANGE_MIN_RST;
            lim_hi_ff[a] <= astc_pkg::CHANGE_MAX_RST;
         end
      end else if (csr_we) begin
         case (csr_index)
            astc_pkg::CSR_X_MIN: lim_lo_ff[0] <= csr_wdata;
            astc_pkg::CSR_X_MAX: lim_hi_ff[0] <= csr_wdata;
            astc_pkg::CSR_Y_MIN: lim_lo_ff[1] <= csr_wdata;
            astc_pkg::CSR_Y_MAX: lim_hi_ff[1] <= csr_wdata;
            astc_pkg::CSR_Z_MIN: lim_lo_ff[2] <= csr_wdata;
            astc_pkg::CSR_Z_MAX: lim_hi_ff[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> src/astc_lane.sv
// One axis lane: sample accumulator, reciprocal-multiply divider and stored averages.
module astc_lane #(
   parameter int SAMPLES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  astc_pkg::lane_ctrl_type ctrl,
   input  astc_pkg::sample_type   sample,
   output astc_pkg::sample_type   normal_avg,
   output astc_pkg::sample_type   stim_avg,
   output astc_pkg::change_type   change
);

   localparam int SUM_W   = astc_pkg::SAMPLE_W + $clog2(SAMPLES);
   localparam int SHIFT   = SUM_W + $clog2(SAMPLES);
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam longint RECIP_VAL = ((longint'(1) << SHIFT) + longint'(SAMPLES) - longint'(1)) /
                                  longint'(SAMPLES);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic [SUM_W-1:0]              mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic [astc_pkg::SAMPLE_W-1:0] quo_ff, quo_in;
   astc_pkg::sample_type          normal_ff, normal_in;
   astc_pkg::sample_type          stim_ff, stim_in;
   logic [PROD_W-1:0]             product;
   astc_pkg::sample_type          avg;

   always_comb begin
      product = PROD_W'(mag_ff) * PROD_W'(RECIP);
      avg     = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

      sum_in    = sum_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      quo_in    = quo_ff;
      normal_in = normal_ff;
      stim_in   = stim_ff;

      if (ctrl.clear || ctrl.div_load) begin
         sum_in = '0;
      end else if (ctrl.add) begin
         sum_in = sum_ff + SUM_W'(sample);
      end

      if (ctrl.div_load) begin
         neg_in = sum_ff[SUM_W-1];
         mag_in = sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
      end

      if (ctrl.div_step) begin
         quo_in = product[SHIFT +: astc_pkg::SAMPLE_W];
      end

      if (ctrl.clear) begin
         normal_in = '0;
         stim_in   = '0;
      end else begin
         if (ctrl.store_normal) begin
            normal_in = avg;
         end
         if (ctrl.store_stim) begin
            stim_in = avg;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         normal_ff <= '0;
         stim_ff   <= '0;
      end else begin
         sum_ff    <= sum_in;
         normal_ff <= normal_in;
         stim_ff   <= stim_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   assign normal_avg = normal_ff;
   assign stim_avg   = stim_ff;
   assign change     = astc_pkg::CHANGE_W'(stim_ff) - astc_pkg::CHANGE_W'(normal_ff);

endmodule

>>> src/astc_window.sv
// Merge of the lane results: checks every axis change against its window.
module astc_window (
   input  astc_pkg::change_type change [astc_pkg::AXES],
   input  astc_pkg::change_type lim_lo [astc_pkg::AXES],
   input  astc_pkg::change_type lim_hi [astc_pkg::AXES],
   output logic                 ok
);

   always_comb begin
      ok = 1'b1;
      for (int a = 0; a < astc_pkg::AXES; a++) begin
         if (change[a] < lim_lo[a] || change[a] > lim_hi[a]) begin
            ok = 1'b0;
         end
      end
   end

endmodule
